>>> src/prefixed_line_capture_assert.svh
// assertion macros used by the prefixed line capture core
`ifndef PREFIXED_LINE_CAPTURE_ASSERT_SVH
`define PREFIXED_LINE_CAPTURE_ASSERT_SVH
`ifndef ASSERT_OFF
// a holds in a cycle, so b holds in the same cycle
`define PLC_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("prefixed line capture check failed");
// a holds in a cycle, so b holds in the next one
`define PLC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("prefixed line capture check failed");
`else
`define PLC_ASSERT_IMPL(label, clk, rst_n, a, b)
`define PLC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> src/plc_pkg.sv
// types, codes and constants of the prefixed line capture block
package plc_pkg;

    localparam int MAX_PREFIX = 8;
    localparam int PFX_IDX_W  = 3;
    localparam int PFX_LEN_W  = 4;
    localparam int CAP_W      = 9;
    localparam int TMO_W      = 20;
    localparam int CHAR_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 2;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_CHAR  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] PH_BEFORE = 2'd0;
    localparam logic [1:0] PH_IN     = 2'd1;
    localparam logic [1:0] PH_AFTER  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_PREFIX_CHARS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PREFIX_LENGTH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAPTURE_LIMIT = 2'd2;

    localparam logic [CAP_W-1:0] CAP_LIMIT_RESET = 9'd64;
    localparam logic [CAP_W-1:0] CAP_LIMIT_MAX   = 9'd256;

    localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0d;
    localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;

    typedef struct packed {
        logic [1:0]        op;
        logic [CHAR_W-1:0] rx_char;
        logic [TMO_W-1:0]  timeout_ms;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] line_char;
        logic              last;
        logic              timed_out;
    } result_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] prefix_chars;
        logic [PFX_LEN_W-1:0]  prefix_length;
        logic [CAP_W-1:0]      capture_limit;
    } cfg_t;

endpackage

>>> src/prefixed_line_capture.sv
// top level of the prefixed line capture block
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser op, tdata rx_char + timeout_ms
//  m_*      out  m_tvalid/m_tready  tdata line_char, tlast last, tuser timed_out
//  cfg_*    in   cfg_we             cfg_addr register, cfg_wdata value
//
// one word per cycle sustained: input register, one decision step, result register
// a word that yields a result has it valid in the cycle after the core takes the word
// the result register stalls the core only while a result waits and m_tready is low
// reset clears control state and loads register defaults (capture limit 64)
module prefixed_line_capture
    import plc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // rx_char[7:0], timeout_ms[27:8], zero pad
    input  logic [1:0]            s_tuser,   // op[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // line_char[7:0]
    output logic                  m_tlast,
    output logic                  m_tuser,   // timed_out[0]
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg_reg, cfg_next;
    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    go;
    result_t res;

    assign s_item.op         = s_tuser;
    assign s_item.rx_char    = s_tdata[CHAR_W-1:0];
    assign s_item.timeout_ms = s_tdata[CHAR_W +: TMO_W];

    assign go = item_valid && out_free;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_PREFIX_CHARS:  cfg_next.prefix_chars  = cfg_wdata;
                CFG_PREFIX_LENGTH: cfg_next.prefix_length = cfg_wdata[PFX_LEN_W-1:0];
                CFG_CAPTURE_LIMIT: cfg_next.capture_limit = cfg_wdata[CAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prefix_chars  <= '0;
            cfg_reg.prefix_length <= '0;
            cfg_reg.capture_limit <= CAP_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    plc_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .take       (go),
        .item_valid (item_valid),
        .item       (item)
    );

    plc_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .item  (item),
        .cfg   (cfg_reg),
        .res   (res)
    );

    plc_out_stage u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (go),
        .res         (res),
        .free        (out_free),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_char      (m_tdata),
        .m_last      (m_tlast),
        .m_timed_out (m_tuser)
    );

endmodule

>>> src/plc_in_stage.sv
// input register holding one accepted word until the core takes it
module plc_in_stage
    import plc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_valid && s_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

>>> src/plc_core.sv
// search state and the per-word decision: prefix match, capture, timeout
module plc_core
    import plc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    go,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

`include "prefixed_line_capture_assert.svh"

    logic                 active_reg, active_next;
    logic [1:0]           phase_reg, phase_next;
    logic [PFX_LEN_W-1:0] mp_reg, mp_next;
    logic [TMO_W-1:0]     time_reg, time_next;
    logic [CAP_W-1:0]     cap_reg, cap_next;

    logic [PFX_LEN_W-1:0] len_used;
    logic [CAP_W-1:0]     lim_used;
    logic [PFX_LEN_W-1:0] mp_eff;
    logic [PFX_LEN_W-1:0] mp_inc;
    logic [CHAR_W-1:0]    pfx_byte;
    logic [TMO_W-1:0]     time_dec;
    logic [CAP_W-1:0]     cap_dec;
    logic                 done;

    always_comb
    begin
        len_used = (cfg.prefix_length > PFX_LEN_W'(MAX_PREFIX)) ?
                   PFX_LEN_W'(MAX_PREFIX) : cfg.prefix_length;
        if (cfg.capture_limit == '0)
        begin
            lim_used = CAP_W'(1);
        end
        else if (cfg.capture_limit > CAP_LIMIT_MAX)
        begin
            lim_used = CAP_LIMIT_MAX;
        end
        else
        begin
            lim_used = cfg.capture_limit;
        end
        // a stale position past a shortened prefix starts over
        mp_eff   = (mp_reg >= len_used) ? '0 : mp_reg;
        mp_inc   = mp_eff + PFX_LEN_W'(1);
        pfx_byte = cfg.prefix_chars[{mp_eff[PFX_IDX_W-1:0], 3'b000} +: CHAR_W];
        time_dec = time_reg - TMO_W'(1);
        cap_dec  = cap_reg - CAP_W'(1);
        done     = (item.rx_char == CHAR_CR) || (item.rx_char == CHAR_LF) ||
                   (item.rx_char == CHAR_NUL) || (cap_dec == '0);
    end

    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        mp_next     = mp_reg;
        time_next   = time_reg;
        cap_next    = cap_reg;
        res         = '0;
        if (go)
        begin
            case (item.op)
                OP_START:
                begin
                    phase_next = PH_BEFORE;
                    mp_next    = '0;
                    if (item.timeout_ms == '0)
                    begin
                        active_next   = 1'b0;
                        time_next     = '0;
                        cap_next      = '0;
                        res.valid     = 1'b1;
                        res.last      = 1'b1;
                        res.timed_out = 1'b1;
                    end
                    else
                    begin
                        active_next = 1'b1;
                        time_next   = item.timeout_ms;
                        cap_next    = lim_used;
                        if (len_used == '0)
                        begin
                            phase_next = PH_AFTER;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (active_reg)
                    begin
                        time_next = time_dec;
                        if (time_dec == '0)
                        begin
                            active_next   = 1'b0;
                            phase_next    = PH_BEFORE;
                            mp_next       = '0;
                            cap_next      = '0;
                            res.valid     = 1'b1;
                            res.last      = 1'b1;
                            res.timed_out = 1'b1;
                        end
                    end
                end
                OP_CHAR:
                begin
                    if (active_reg)
                    begin
                        if (phase_reg == PH_AFTER)
                        begin
                            cap_next      = cap_dec;
                            res.valid     = 1'b1;
                            res.line_char = item.rx_char;
                            res.last      = done;
                            if (done)
                            begin
                                active_next = 1'b0;
                                phase_next  = PH_BEFORE;
                                mp_next     = '0;
                                time_next   = '0;
                                cap_next    = '0;
                            end
                        end
                        else if (len_used == '0)
                        begin
                            phase_next = PH_AFTER;
                            mp_next    = '0;
                        end
                        else if (item.rx_char == pfx_byte)
                        begin
                            if (mp_inc >= len_used)
                            begin
                                phase_next = PH_AFTER;
                                mp_next    = '0;
                            end
                            else
                            begin
                                phase_next = PH_IN;
                                mp_next    = mp_inc;
                            end
                        end
                        else
                        begin
                            // mismatched character is dropped, not rechecked
                            phase_next = PH_BEFORE;
                            mp_next    = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= PH_BEFORE;
            mp_reg     <= '0;
            time_reg   <= '0;
            cap_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            mp_reg     <= mp_next;
            time_reg   <= time_next;
            cap_reg    <= cap_next;
        end
    end

    `PLC_ASSERT_IMPL(a_idle_clean, clk, rst_n, !active_reg,
        (phase_reg == PH_BEFORE) && (mp_reg == '0) && (cap_reg == '0))
    `PLC_ASSERT_IMPL(a_active_budget, clk, rst_n, active_reg,
        (time_reg != '0) && (cap_reg != '0))
    `PLC_ASSERT_IMPL(a_pos_in_prefix, clk, rst_n, phase_reg != PH_IN,
        mp_reg == '0)
    `PLC_ASSERT_NEXT(a_last_goes_idle, clk, rst_n, go && res.valid && res.last,
        !active_reg)

endmodule

>>> src/plc_out_stage.sv
// result register in front of the master side
module plc_out_stage
    import plc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  result_t           res,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_char,
    output logic              m_last,
    output logic              m_timed_out
);

    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic              to_reg;

    assign free        = !valid_reg || m_ready;
    assign m_valid     = valid_reg;
    assign m_char      = char_reg;
    assign m_last      = last_reg;
    assign m_timed_out = to_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res.valid;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.valid)
        begin
            char_reg <= res.line_char;
            last_reg <= res.last;
            to_reg   <= res.timed_out;
        end
    end

endmodule
